// ===== hw/rtl/ddsc_pkg.sv =====
// shared constants of the distinct destination scan counter
package ddsc_pkg;

  localparam int unsigned PAIR_ENTRIES   = 1024;
  localparam int unsigned QUEUE_DEPTH    = 1024;
  localparam int unsigned SOURCE_ENTRIES = 256;

  localparam int unsigned PAIR_AW  = $clog2(PAIR_ENTRIES);
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned SRC_AW   = $clog2(SOURCE_ENTRIES);

  localparam logic [63:0] WINDOW_RESET = 64'd50000000000;
  localparam logic [11:0] EXPIRE_MAX   = 12'd2048;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [15:0] ETH_HDR_LEN  = 16'd14;
  localparam logic [15:0] IPV4_MIN_LEN = 16'd34;

  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

endpackage

// ===== hw/rtl/ddsc_in_if.sv =====
// input channel carrying one packet header summary
interface ddsc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_length;
  logic [15:0] ether_type;
  logic [31:0] source_addr;
  logic [31:0] dest_addr;
  logic [63:0] now_ns;
  modport source (output valid, frame_length, ether_type, source_addr, dest_addr, now_ns,
                  input ready);
  modport sink (input valid, frame_length, ether_type, source_addr, dest_addr, now_ns,
                output ready);
endinterface

// ===== hw/rtl/ddsc_out_if.sv =====
// output channel carrying one result per packet
interface ddsc_out_if;
  logic        valid;
  logic        ready;
  logic        verdict;
  logic        new_pair;
  logic [15:0] source_count;
  logic [11:0] expired_count;
  modport source (output valid, verdict, new_pair, source_count, expired_count,
                  input ready);
  modport sink (input valid, verdict, new_pair, source_count, expired_count,
                output ready);
endinterface

// ===== hw/rtl/distinct_destination_scan_counter_core.sv =====
// distinct destination scan counter: per source count of distinct recent destinations
// One packet is handled at a time. A short or non-IPv4 frame goes straight to the result. An IPv4
// frame walks the pair memory (up to 1024 pairs), then, if the pair is new, walks the source
// memory (up to 256 sources) for its own source, again for the source of every expired queue
// entry, and once more at the end to fetch the final count. Worst case is therefore set by
// these linear scans over single-port memories. Pair and source tables only grow, so fill
// counts mark their valid region and no clearing pass is needed after reset. The next packet
// is taken while a finished result still waits in the output register.
module distinct_destination_scan_counter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  ddsc_in_if.sink     in_i,
  ddsc_out_if.source  out_o
);

  localparam int unsigned PAIR_AW  = ddsc_pkg::PAIR_AW;
  localparam int unsigned SRC_AW   = ddsc_pkg::SRC_AW;
  localparam int unsigned QUEUE_AW = ddsc_pkg::QUEUE_AW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_P_RD, ST_P_CMP, ST_S_RD, ST_S_CMP, ST_E_RD, ST_E_CMP, ST_FIN
  } state_e;

  // what a source lookup is for
  typedef enum logic [1:0] {PH_RAISE, PH_EXPIRE, PH_FINAL} phase_e;

  state_e state_q;
  phase_e phase_q;

  // configuration
  logic [63:0] window_q;
  logic [11:0] limit_q;

  // latched packet
  logic [31:0] src_q;
  logic [31:0] dst_q;
  logic [63:0] now_q;

  // scan and bookkeeping
  logic [PAIR_AW:0]  pair_fill_q;
  logic [SRC_AW:0]   src_fill_q;
  logic [PAIR_AW:0]  pidx_q;
  logic [SRC_AW:0]   sidx_q;
  logic [31:0]       tgt_q;
  logic [QUEUE_AW-1:0] q_head_q;
  logic [QUEUE_AW:0]   q_level_q;
  logic [11:0]       expired_q;
  logic              fresh_q;

  // result register
  logic        out_valid_q;
  logic        res_verdict_q;
  logic        res_new_q;
  logic [15:0] res_count_q;
  logic [11:0] res_exp_q;
  logic        fin_verdict_q;
  logic [15:0] fin_count_q;

  // memories
  logic [63:0] pair_mem [ddsc_pkg::PAIR_ENTRIES];
  logic [47:0] src_mem  [ddsc_pkg::SOURCE_ENTRIES];
  logic [95:0] q_mem    [ddsc_pkg::QUEUE_DEPTH];

  logic [63:0] pair_rd_q;
  logic [47:0] src_rd_q;
  logic [95:0] q_rd_q;

  logic              pair_we;
  logic              src_we;
  logic [SRC_AW-1:0] src_waddr;
  logic [47:0]       src_wdata;
  logic              q_we;
  logic [QUEUE_AW-1:0] q_slot;

  logic [11:0] limit_eff;
  logic [15:0] src_cnt_rd;
  logic [31:0] src_key_rd;
  logic [63:0] age;
  logic        s_hit;
  logic        s_end;
  logic        in_xfer;
  logic        fin_load;

  assign limit_eff  = (limit_q > ddsc_pkg::EXPIRE_MAX) ? ddsc_pkg::EXPIRE_MAX : limit_q;
  assign src_key_rd = src_rd_q[47:16];
  assign src_cnt_rd = src_rd_q[15:0];
  assign age        = now_q - q_rd_q[63:0];
  assign s_hit      = (src_key_rd == tgt_q);
  assign s_end      = (sidx_q == src_fill_q);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign fin_load   = (state_q == ST_FIN) && (!out_valid_q || out_o.ready);

  assign in_i.ready          = (state_q == ST_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.verdict       = res_verdict_q;
  assign out_o.new_pair      = res_new_q;
  assign out_o.source_count  = res_count_q;
  assign out_o.expired_count = res_exp_q;

  // queue slot for a push: overwrite the oldest when full
  assign q_slot = (q_level_q == (QUEUE_AW+1)'(ddsc_pkg::QUEUE_DEPTH)) ? q_head_q
                : q_head_q + q_level_q[QUEUE_AW-1:0];

  // memory writes
  always_comb begin
    pair_we   = 1'b0;
    src_we    = 1'b0;
    src_waddr = sidx_q[SRC_AW-1:0];
    src_wdata = {tgt_q, src_cnt_rd};
    q_we      = 1'b0;
    if (state_q == ST_P_RD && pidx_q == pair_fill_q &&
        pair_fill_q != (PAIR_AW+1)'(ddsc_pkg::PAIR_ENTRIES)) begin
      pair_we = 1'b1;
    end
    if (state_q == ST_S_CMP && s_hit) begin
      if (phase_q == PH_RAISE && src_cnt_rd != ddsc_pkg::COUNT_MAX) begin
        src_we    = 1'b1;
        src_wdata = {tgt_q, src_cnt_rd + 16'd1};
      end else if (phase_q == PH_EXPIRE && src_cnt_rd != 16'd0) begin
        src_we    = 1'b1;
        src_wdata = {tgt_q, src_cnt_rd - 16'd1};
      end
    end
    // unknown source gets a new entry while there is room
    if (state_q == ST_S_RD && s_end && phase_q == PH_RAISE &&
        src_fill_q != (SRC_AW+1)'(ddsc_pkg::SOURCE_ENTRIES)) begin
      src_we    = 1'b1;
      src_waddr = src_fill_q[SRC_AW-1:0];
      src_wdata = {tgt_q, 16'd1};
    end
    if (state_q == ST_S_RD && phase_q == PH_RAISE && s_end) begin
      q_we = 1'b1;
    end
    if (state_q == ST_S_CMP && phase_q == PH_RAISE && s_hit) begin
      q_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_we) begin
      pair_mem[pair_fill_q[PAIR_AW-1:0]] <= {src_q, dst_q};
    end
    pair_rd_q <= pair_mem[pidx_q[PAIR_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_mem[src_waddr] <= src_wdata;
    end
    src_rd_q <= src_mem[sidx_q[SRC_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_slot] <= {src_q, now_q};
    end
    q_rd_q <= q_mem[q_head_q];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_q       <= PH_RAISE;
      window_q      <= ddsc_pkg::WINDOW_RESET;
      limit_q       <= ddsc_pkg::EXPIRE_MAX;
      src_q         <= '0;
      dst_q         <= '0;
      now_q         <= '0;
      tgt_q         <= '0;
      pair_fill_q   <= '0;
      src_fill_q    <= '0;
      pidx_q        <= '0;
      sidx_q        <= '0;
      q_head_q      <= '0;
      q_level_q     <= '0;
      expired_q     <= '0;
      fresh_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      fin_verdict_q <= 1'b0;
      fin_count_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == ddsc_pkg::REG_WINDOW) begin
          window_q <= cfg_data_i;
        end else begin
          limit_q <= cfg_data_i[11:0];
        end
      end
      if (out_valid_q && out_o.ready && !fin_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            src_q         <= in_i.source_addr;
            dst_q         <= in_i.dest_addr;
            now_q         <= in_i.now_ns;
            fresh_q       <= 1'b0;
            expired_q     <= '0;
            fin_count_q   <= '0;
            pidx_q        <= '0;
            fin_verdict_q <= 1'b0;
            if (in_i.frame_length < ddsc_pkg::ETH_HDR_LEN) begin
              fin_verdict_q <= 1'b1;
              state_q       <= ST_FIN;
            end else if (in_i.ether_type != ddsc_pkg::ETYPE_IPV4) begin
              state_q <= ST_FIN;
            end else if (in_i.frame_length < ddsc_pkg::IPV4_MIN_LEN) begin
              fin_verdict_q <= 1'b1;
              state_q       <= ST_FIN;
            end else begin
              state_q <= ST_P_RD;
            end
          end
        end
        ST_P_RD: begin
          if (pidx_q == pair_fill_q) begin
            // pair not seen: record it if there is room, then raise the source
            fresh_q <= 1'b1;
            if (pair_we) begin
              pair_fill_q <= pair_fill_q + 1'b1;
            end
            tgt_q   <= src_q;
            phase_q <= PH_RAISE;
            sidx_q  <= '0;
            state_q <= ST_S_RD;
          end else begin
            state_q <= ST_P_CMP;
          end
        end
        ST_P_CMP: begin
          if (pair_rd_q == {src_q, dst_q}) begin
            state_q <= ST_E_RD;
          end else begin
            pidx_q  <= pidx_q + 1'b1;
            state_q <= ST_P_RD;
          end
        end
        ST_S_RD: begin
          if (s_end) begin
            // source not in the table
            if (phase_q == PH_RAISE) begin
              if (src_we) begin
                src_fill_q <= src_fill_q + 1'b1;
              end
              state_q <= ST_E_RD;
            end else if (phase_q == PH_EXPIRE) begin
              state_q <= ST_E_RD;
            end else begin
              fin_count_q <= '0;
              state_q     <= ST_FIN;
            end
          end else begin
            state_q <= ST_S_CMP;
          end
        end
        ST_S_CMP: begin
          if (s_hit) begin
            if (phase_q == PH_FINAL) begin
              fin_count_q <= src_cnt_rd;
              state_q     <= ST_FIN;
            end else begin
              state_q <= ST_E_RD;
            end
          end else begin
            sidx_q  <= sidx_q + 1'b1;
            state_q <= ST_S_RD;
          end
        end
        ST_E_RD: begin
          if (expired_q < limit_eff && q_level_q != '0) begin
            state_q <= ST_E_CMP;
          end else begin
            tgt_q   <= src_q;
            phase_q <= PH_FINAL;
            sidx_q  <= '0;
            state_q <= ST_S_RD;
          end
        end
        ST_E_CMP: begin
          if (age > window_q) begin
            q_head_q  <= q_head_q + 1'b1;
            q_level_q <= q_level_q - 1'b1;
            expired_q <= expired_q + 12'd1;
            tgt_q     <= q_rd_q[95:64];
            phase_q   <= PH_EXPIRE;
            sidx_q    <= '0;
            state_q   <= ST_S_RD;
          end else begin
            tgt_q   <= src_q;
            phase_q <= PH_FINAL;
            sidx_q  <= '0;
            state_q <= ST_S_RD;
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      // the push happens at the end of the raise lookup, even when the count is saturated or the table is full
      if (q_we) begin
        if (q_level_q == (QUEUE_AW+1)'(ddsc_pkg::QUEUE_DEPTH)) begin
          q_head_q <= q_head_q + 1'b1;
        end else begin
          q_level_q <= q_level_q + 1'b1;
        end
      end
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      res_verdict_q <= fin_verdict_q;
      res_new_q     <= fresh_q;
      res_count_q   <= fin_count_q;
      res_exp_q     <= expired_q;
    end
  end

  // queue never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level_q <= (QUEUE_AW+1)'(ddsc_pkg::QUEUE_DEPTH))
    else $error("queue level beyond depth");

  // an aborted frame reports nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load && fin_verdict_q |=> !res_new_q && res_count_q == '0 && res_exp_q == '0)
    else $error("aborted frame with nonzero fields");

  // expiries per packet stay within EXPIRE_MAX
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |-> expired_q <= ddsc_pkg::EXPIRE_MAX)
    else $error("too many expiries");

  // source fill count within table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    src_fill_q <= (SRC_AW+1)'(ddsc_pkg::SOURCE_ENTRIES))
    else $error("source fill beyond table");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the distinct destination scan counter core
module tb_top;

  typedef struct {
    logic [15:0] len;
    logic [15:0] etype;
    logic [31:0] src;
    logic [31:0] dst;
    logic [63:0] now;
  } pkt_t;

  typedef struct {
    logic        verdict;
    logic        fresh;
    logic [15:0] count;
    logic [11:0] expired;
  } scan_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = ddsc_pkg::REG_WINDOW;
  logic [63:0] cfg_data_i = '0;

  ddsc_in_if in_if ();
  ddsc_out_if out_if ();

  distinct_destination_scan_counter_core u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  always #2 clk_i = ~clk_i;

  // predictor state: pair memory, source counters, access queue, registers
  logic [63:0] pm_key   [ddsc_pkg::PAIR_ENTRIES];
  bit          pm_ok    [ddsc_pkg::PAIR_ENTRIES];
  int          pairs_used;
  logic [31:0] sm_key   [ddsc_pkg::SOURCE_ENTRIES];
  logic [15:0] sm_count [ddsc_pkg::SOURCE_ENTRIES];
  bit          sm_ok    [ddsc_pkg::SOURCE_ENTRIES];
  logic [31:0] aq_src   [ddsc_pkg::QUEUE_DEPTH];
  logic [63:0] aq_time  [ddsc_pkg::QUEUE_DEPTH];
  int          aq_head;
  int          aq_level;
  logic [63:0] window_reg = ddsc_pkg::WINDOW_RESET;
  logic [11:0] limit_reg = ddsc_pkg::EXPIRE_MAX;

  scan_res_t   pending_results[$];
  int          mismatches;
  int          stall_pct;
  int          idle_pct;
  bit          hold_out;
  logic [63:0] t_ns;

  function automatic int source_slot(logic [31:0] a);
    for (int i = 0; i < ddsc_pkg::SOURCE_ENTRIES; i++)
      if (sm_ok[i] && sm_key[i] == a) return i;
    return -1;
  endfunction

  // expected result of one packet, updating the predictor state
  function automatic scan_res_t count_destinations(pkt_t p);
    scan_res_t r;
    bit seen;
    int free_slot;
    int s;
    int slot;
    int lim;
    r = '{default: '0};
    seen = 1'b0;
    free_slot = -1;
    if (p.len < ddsc_pkg::ETH_HDR_LEN) begin
      r.verdict = 1'b1;
      return r;
    end
    if (p.etype != ddsc_pkg::ETYPE_IPV4) return r;
    if (p.len < ddsc_pkg::IPV4_MIN_LEN) begin
      r.verdict = 1'b1;
      return r;
    end
    for (int i = 0; i < ddsc_pkg::PAIR_ENTRIES; i++) begin
      if (pm_ok[i]) begin
        if (pm_key[i] == {p.src, p.dst}) seen = 1'b1;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (!seen) begin
      // full pair memory: not stored, but still treated as new
      if (free_slot >= 0) begin
        pm_ok[free_slot] = 1'b1;
        pm_key[free_slot] = {p.src, p.dst};
        pairs_used++;
      end
      s = source_slot(p.src);
      if (s >= 0) begin
        if (sm_count[s] != ddsc_pkg::COUNT_MAX) sm_count[s]++;
      end else begin
        for (int i = 0; i < ddsc_pkg::SOURCE_ENTRIES; i++)
          if (!sm_ok[i]) begin
            sm_ok[i] = 1'b1;
            sm_key[i] = p.src;
            sm_count[i] = 16'd1;
            break;
          end
      end
      // full queue drops its oldest entry without touching any count
      if (aq_level >= ddsc_pkg::QUEUE_DEPTH) begin
        slot = aq_head;
        aq_head = (aq_head + 1) % ddsc_pkg::QUEUE_DEPTH;
      end else begin
        slot = (aq_head + aq_level) % ddsc_pkg::QUEUE_DEPTH;
        aq_level++;
      end
      aq_src[slot] = p.src;
      aq_time[slot] = p.now;
    end
    lim = (limit_reg > ddsc_pkg::EXPIRE_MAX) ? ddsc_pkg::EXPIRE_MAX : limit_reg;
    while (r.expired < lim && aq_level > 0 && (p.now - aq_time[aq_head]) > window_reg) begin
      s = source_slot(aq_src[aq_head]);
      if (s >= 0 && sm_count[s] != 0) sm_count[s]--;
      aq_head = (aq_head + 1) % ddsc_pkg::QUEUE_DEPTH;
      aq_level--;
      r.expired++;
    end
    s = source_slot(p.src);
    r.fresh = !seen;
    r.count = (s >= 0) ? sm_count[s] : 16'd0;
    return r;
  endfunction

  // receiver: random stalls, or a long hold-off while hold_out is set
  always @(negedge clk_i) begin
    out_if.ready <= hold_out ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    scan_res_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result transfer with nothing expected");
      end else begin
        e = pending_results.pop_front();
        if (out_if.verdict !== e.verdict || out_if.new_pair !== e.fresh ||
            out_if.source_count !== e.count || out_if.expired_count !== e.expired) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp v=%0d n=%0d c=%0d x=%0d got v=%0d n=%0d c=%0d x=%0d",
                     e.verdict, e.fresh, e.count, e.expired, out_if.verdict,
                     out_if.new_pair, out_if.source_count, out_if.expired_count);
        end
      end
    end
  end

  // one input transfer, with a random idle gap ahead of it
  task automatic send_item(pkt_t p);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.frame_length <= p.len;
    in_if.ether_type <= p.etype;
    in_if.source_addr <= p.src;
    in_if.dest_addr <= p.dst;
    in_if.now_ns <= p.now;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_results.push_back(count_destinations(p));
  endtask

  // packet at the running time, which then moves on by step
  task automatic send_pkt(logic [15:0] len, logic [15:0] et, logic [31:0] s, logic [31:0] d,
                          logic [63:0] step = 1);
    pkt_t p;
    p = '{len: len, etype: et, src: s, dst: d, now: t_ns};
    t_ns += step;
    send_item(p);
  endtask

  // stop sending and wait until every result has arrived
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [63:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ddsc_pkg::REG_WINDOW) window_reg = val;
    else limit_reg = val[11:0];
  endtask

  task automatic stall_output(int cycles);
    hold_out = 1'b1;
    repeat (cycles) @(negedge clk_i);
    hold_out = 1'b0;
  endtask

  // mostly well-formed IPv4 from small address pools, rest random noise
  task automatic send_random();
    pkt_t p;
    if ($urandom_range(99) < 85) begin
      p.len = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(34, 1514));
      p.etype = ddsc_pkg::ETYPE_IPV4;
      p.src = 32'h0A00_0000 | $urandom_range(11);
      p.dst = 32'hC0A8_0000 | $urandom_range(19);
    end else begin
      p.len = 16'($urandom);
      p.etype = ($urandom_range(1) == 0) ? ddsc_pkg::ETYPE_IPV4 : 16'($urandom);
      p.src = $urandom;
      p.dst = $urandom;
      // keep random addresses off the IPv4 path so pair memory stays small
      if (p.len >= ddsc_pkg::IPV4_MIN_LEN && p.etype == ddsc_pkg::ETYPE_IPV4)
        p.len = 16'($urandom_range(13));
    end
    // time mostly creeps forward, rarely jumps back
    if ($urandom_range(49) == 0) t_ns -= $urandom_range(3000);
    else t_ns += $urandom_range(400);
    p.now = t_ns;
    send_item(p);
  endtask

  task automatic test_directed();
    send_pkt(16'd0, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0001, 32'hC0A8_0001);   // empty frame
    send_pkt(16'd13, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0001, 32'hC0A8_0001);  // below header
    send_pkt(16'd14, 16'h86DD, 32'h0A00_0001, 32'hC0A8_0001);      // non-IPv4 passes
    send_pkt(16'd14, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0001, 32'hC0A8_0001);  // short IPv4
    send_pkt(16'd33, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0001, 32'hC0A8_0001);
    send_pkt(16'd34, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0001, 32'hC0A8_0001);  // first pair
    send_pkt(16'd60, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0001, 32'hC0A8_0001);  // repeated pair
    send_pkt(16'd60, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0001, 32'hC0A8_0002);  // second dest
    send_pkt(16'hFFFF, 16'hFFFF, '1, '1);
    send_pkt(16'hFFFF, ddsc_pkg::ETYPE_IPV4, '1, '1);
    send_pkt(16'd64, ddsc_pkg::ETYPE_IPV4, '0, '0);
    send_pkt(16'd64, 16'h0000, 32'h5555_5555, 32'hAAAA_AAAA);
    // window of one: every queued access expires on the next packet
    write_reg(ddsc_pkg::REG_WINDOW, 64'd1);
    send_pkt(16'd64, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0001, 32'hC0A8_0003, 64'd5);
    write_reg(ddsc_pkg::REG_LIMIT, 64'd0);                         // expires nothing
    send_pkt(16'd64, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0002, 32'hC0A8_0001, 64'd5);
    send_pkt(16'd64, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0002, 32'hC0A8_0002, 64'd5);
    write_reg(ddsc_pkg::REG_LIMIT, 64'd1);
    send_pkt(16'd64, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0002, 32'hC0A8_0001, 64'd5);
    write_reg(ddsc_pkg::REG_LIMIT, 64'hFFF);                       // acts as the maximum
    // time near the top, then back near zero: ages wrap to small values that stay within the window
    t_ns = 64'hFFFF_FFFF_FFFF_FF00;
    send_pkt(16'd64, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0003, 32'hC0A8_0001);
    write_reg(ddsc_pkg::REG_WINDOW, '1);
    send_pkt(16'd64, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0003, 32'hC0A8_0002);
    t_ns = 64'd10;
    write_reg(ddsc_pkg::REG_WINDOW, 64'd1000);
    send_pkt(16'd64, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0003, 32'hC0A8_0003);
    write_reg(ddsc_pkg::REG_LIMIT, 64'(ddsc_pkg::EXPIRE_MAX));
  endtask

  task automatic test_random();
    int windows[4] = '{2000, 600, 50000, 150};
    int limits[4] = '{2048, 3, 1, 2047};
    int stalls[4] = '{0, 0, 73, 37};
    int idles[4] = '{0, 73, 0, 37};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(ddsc_pkg::REG_WINDOW, 64'(windows[ph]));
      write_reg(ddsc_pkg::REG_LIMIT, 64'(limits[ph]));
      stall_pct = stalls[ph];
      idle_pct = idles[ph];
      repeat (35) send_random();
    end
    stall_pct = 20;
    idle_pct = 20;
  endtask

  // receiver holds off while the sender keeps offering packets
  task automatic test_backpressure();
    fork
      stall_output(400);
      begin
        idle_pct = 0;
        repeat (12) send_random();
      end
    join
    idle_pct = 20;
  endtask

  // more sources than the counter table holds, some of them expiring later
  task automatic test_source_overflow();
    write_reg(ddsc_pkg::REG_WINDOW, '1);
    for (int i = 0; i < ddsc_pkg::SOURCE_ENTRIES + 8; i++)
      send_pkt(16'd64, ddsc_pkg::ETYPE_IPV4, 32'h0B00_0000 + i, 32'hC0A8_0100, 64'd3);
    write_reg(ddsc_pkg::REG_WINDOW, 64'd2);
    write_reg(ddsc_pkg::REG_LIMIT, 64'd6);
    t_ns += 100;
    for (int i = 0; i < 6; i++)
      send_pkt(16'd64, ddsc_pkg::ETYPE_IPV4, 32'h0B00_0000 + ddsc_pkg::SOURCE_ENTRIES + i,
               32'hC0A8_0100);
    for (int i = 0; i < 10; i++)
      send_pkt(16'd64, 16'h0806, 32'h0B00_0000, 32'hC0A8_0100);
    for (int i = 0; i < 10; i++)
      send_pkt(16'd64, ddsc_pkg::ETYPE_IPV4, 32'h0B00_0000 + i, 32'hC0A8_0100);
  endtask

  // pair memory and access queue both run full
  task automatic test_pair_overflow();
    int k;
    k = 0;
    write_reg(ddsc_pkg::REG_WINDOW, '1);
    while (pairs_used < ddsc_pkg::PAIR_ENTRIES) begin
      send_pkt(16'd64, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0000 + (k % 12), 32'hD000_0000 + k);
      k++;
    end
    repeat (8) begin
      send_pkt(16'd64, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0000 + (k % 12), 32'hD000_0000 + k);
      k++;
    end
    // an unstored pair keeps looking new
    repeat (3) send_pkt(16'd64, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0001, 32'hD000_0000 + k);
    write_reg(ddsc_pkg::REG_WINDOW, 64'd50);
    write_reg(ddsc_pkg::REG_LIMIT, 64'd4);
    t_ns += 1000;
    repeat (6) send_pkt(16'd64, ddsc_pkg::ETYPE_IPV4, 32'h0A00_0002, 32'hD000_0000);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.frame_length = '0;
    in_if.ether_type = '0;
    in_if.source_addr = '0;
    in_if.dest_addr = '0;
    in_if.now_ns = '0;
    out_if.ready = 1'b0;
    hold_out = 1'b0;
    stall_pct = 0;
    idle_pct = 0;
    mismatches = 0;
    pairs_used = 0;
    aq_head = 0;
    aq_level = 0;
    t_ns = 64'd100;
    for (int i = 0; i < ddsc_pkg::PAIR_ENTRIES; i++) pm_ok[i] = 1'b0;
    for (int i = 0; i < ddsc_pkg::SOURCE_ENTRIES; i++) sm_ok[i] = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    test_source_overflow();
    test_pair_overflow();
    drain();
    repeat (100) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run time limit, far above the slowest legal run
  initial begin
    #200ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
